@@ src/pfa_pkg.sv @@
// Package for the polygon fan area block: shared widths and the square root status type.
// No dependencies; used by the top level, the square root unit and the port checker.

package pfa_pkg;

	localparam int COORD_W = 20;                 // one vertex coordinate, signed Q10.10
	localparam int S_DATA_W = 64;                // three coordinates padded to whole bytes
	localparam int AREA_W = 48;                  // result area, 20 fraction bits
	localparam int SUM_W = AREA_W + 1;           // accumulator of full triangle lengths
	localparam int RAD_W = 88;                   // radicand: sum of three squares, padded
	localparam int ROOT_W = RAD_W / 2;           // one root bit per radicand bit pair
	localparam int ITER_W = $clog2(ROOT_W);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

endpackage

@@ src/pfa_isqrt.sv @@
// Iterative integer square root, one root bit per cycle (restoring digit method).
// Depends on pfa_pkg for the radicand and root widths and the status struct.

module pfa_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pfa_pkg::RAD_W-1:0]     radicand,
	output pfa_pkg::sqrt_stat_t           stat,
	output logic [pfa_pkg::ROOT_W-1:0]    root
);

	localparam int REM_W = pfa_pkg::ROOT_W + 2;

	logic [pfa_pkg::RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]           rem_q;
	logic [pfa_pkg::ROOT_W-1:0] root_q;
	logic [pfa_pkg::ITER_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic             fits;

	assign rem_sh = {rem_q, rad_q[pfa_pkg::RAD_W-1 -: 2]};
	assign trial  = (REM_W + 2)'({root_q, 2'b01});
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pfa_pkg::ITER_W'(pfa_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[pfa_pkg::RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= REM_W'(rem_sh - trial);
				root_q <= {root_q[pfa_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(rem_sh);
				root_q <= {root_q[pfa_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

@@ src/polygon_fan_area.sv @@
// Polygon fan area: one 22x22 multiplier and one wide adder under a step sequencer,
// plus the iterative square root unit pfa_isqrt. Depends on pfa_pkg.
// Sequence: the first two vertices of a polygon are only stored; every later vertex runs
// the difference step, 15 multiplier steps and 44 square root steps before the next is taken.
// A result shows on m_tvalid the cycle after its last vertex finishes; it waits in the output
// register while the next polygon streams in. Reset (arst_n low) clears count, sum and valids.

module polygon_fan_area #(
	parameter int MAX_VERTICES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// vertex stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pfa_pkg::S_DATA_W-1:0]   s_tdata,   // pos_x[19:0], pos_y[39:20], pos_z[59:40]
	input  logic                           s_tlast,   // final_vertex
	// area stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pfa_pkg::AREA_W-1:0]     m_tdata,   // poly_area[47:0]
	output logic                           m_tuser    // too_few[0]
);

	localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
	localparam int PROD_W    = 44;                // 22x22 signed product
	localparam int DIFF_W    = pfa_pkg::COORD_W + 1;
	localparam int CROSS_W   = 2 * DIFF_W + 1;    // one cross product component
	localparam int ACC_W     = 86;                // sum of three squares, signed headroom
	localparam int HALF_W    = 21;                // low split of a cross component
	localparam logic [3:0] STEP_LAST = 4'd14;

	// one-hot sequencer states
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIFF  = 7'b0000010,
		ST_MUL   = 7'b0000100,
		ST_DRAIN = 7'b0001000,
		ST_ROOT  = 7'b0010000,
		ST_WAIT  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		SH_0  = 2'd0,
		SH_22 = 2'd1,
		SH_42 = 2'd2
	} shift_t;

	// what the adder does with the product of one step
	typedef struct packed {
		logic       to_sum;   // target the sum of squares, else a cross component
		logic       load;     // start from zero
		logic       neg;      // subtract the product
		logic [1:0] dst;      // cross component index
		shift_t     shift;
	} acc_ctl_t;

	state_t state_q;

	pfa_pkg::coord_t            cur_q   [3];
	pfa_pkg::coord_t            first_q [3];
	pfa_pkg::coord_t            prev_q  [3];
	logic                       last_q;
	logic [CNT_W-1:0]           count_q;
	logic [pfa_pkg::SUM_W-1:0]  sum_q;

	logic signed [DIFF_W-1:0]   a_q [3];
	logic signed [DIFF_W-1:0]   b_q [3];
	logic [3:0]                 step_q;

	logic signed [PROD_W-1:0]   prod_s1;
	acc_ctl_t                   ctl_s1;
	logic                       mul_vld_s1;

	logic signed [CROSS_W-1:0]  cross_q [3];
	logic signed [ACC_W-1:0]    sumsq_q;

	logic                          m_tvalid_q;
	logic [pfa_pkg::AREA_W-1:0]    m_tdata_q;
	logic                          m_tuser_q;

	logic signed [21:0]         mul_a;
	logic signed [21:0]         mul_b;
	acc_ctl_t                   ctl_c;
	logic signed [21:0]         ch [3];
	logic signed [21:0]         cl [3];
	logic signed [21:0]         av [3];
	logic signed [21:0]         bv [3];

	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    addend;
	logic signed [ACC_W-1:0]    base;
	logic signed [ACC_W-1:0]    acc_res;

	pfa_pkg::sqrt_stat_t           sq_stat;
	logic [pfa_pkg::ROOT_W-1:0]    sq_root;
	logic [pfa_pkg::RAD_W-1:0]     radicand;
	logic                          sq_start;
	logic [pfa_pkg::SUM_W:0]       sum_ext;

	logic                 in_fire;
	logic                 out_free;
	logic                 finish;
	logic [CNT_W-1:0]     count_inc;
	logic                 too_few;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	// a non-final vertex never waits on the output side
	assign finish   = (state_q == ST_DONE) && (!last_q || out_free);

	assign count_inc = (count_q < CNT_W'(MAX_VERTICES)) ? count_q + 1'b1 : count_q;
	assign too_few   = (count_inc < CNT_W'(3));

	// split each cross component: signed high part, unsigned low part; widen the differences
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ch[i] = cross_q[i][CROSS_W-1:HALF_W];
			cl[i] = $signed({1'b0, cross_q[i][HALF_W-1:0]});
			av[i] = $signed({a_q[i][DIFF_W-1], a_q[i]});
			bv[i] = $signed({b_q[i][DIFF_W-1], b_q[i]});
		end
	end

	// step table: six cross product terms, then three partial squares per component
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		ctl_c = '{to_sum: 1'b0, load: 1'b0, neg: 1'b0, dst: 2'd0, shift: SH_0};
		case (step_q)
			4'd0: begin mul_a = av[1]; mul_b = bv[2]; ctl_c.dst = 2'd0; ctl_c.load = 1'b1; end
			4'd1: begin mul_a = av[2]; mul_b = bv[1]; ctl_c.dst = 2'd0; ctl_c.neg = 1'b1; end
			4'd2: begin mul_a = av[2]; mul_b = bv[0]; ctl_c.dst = 2'd1; ctl_c.load = 1'b1; end
			4'd3: begin mul_a = av[0]; mul_b = bv[2]; ctl_c.dst = 2'd1; ctl_c.neg = 1'b1; end
			4'd4: begin mul_a = av[0]; mul_b = bv[1]; ctl_c.dst = 2'd2; ctl_c.load = 1'b1; end
			4'd5: begin mul_a = av[1]; mul_b = bv[0]; ctl_c.dst = 2'd2; ctl_c.neg = 1'b1; end
			4'd6: begin
				mul_a = ch[0]; mul_b = ch[0];
				ctl_c.to_sum = 1'b1; ctl_c.load = 1'b1; ctl_c.shift = SH_42;
			end
			4'd7: begin mul_a = ch[0]; mul_b = cl[0]; ctl_c.to_sum = 1'b1; ctl_c.shift = SH_22; end
			4'd8: begin mul_a = cl[0]; mul_b = cl[0]; ctl_c.to_sum = 1'b1; end
			4'd9: begin mul_a = ch[1]; mul_b = ch[1]; ctl_c.to_sum = 1'b1; ctl_c.shift = SH_42; end
			4'd10: begin mul_a = ch[1]; mul_b = cl[1]; ctl_c.to_sum = 1'b1; ctl_c.shift = SH_22; end
			4'd11: begin mul_a = cl[1]; mul_b = cl[1]; ctl_c.to_sum = 1'b1; end
			4'd12: begin mul_a = ch[2]; mul_b = ch[2]; ctl_c.to_sum = 1'b1; ctl_c.shift = SH_42; end
			4'd13: begin mul_a = ch[2]; mul_b = cl[2]; ctl_c.to_sum = 1'b1; ctl_c.shift = SH_22; end
			4'd14: begin mul_a = cl[2]; mul_b = cl[2]; ctl_c.to_sum = 1'b1; end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// shared adder behind the product register
	always_comb begin
		prod_ext = $signed({{(ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1});
		case (ctl_s1.shift)
			SH_22:   addend = prod_ext <<< 22;
			SH_42:   addend = prod_ext <<< 42;
			default: addend = prod_ext;
		endcase
		if (ctl_s1.load) begin
			base = '0;
		end else if (ctl_s1.to_sum) begin
			base = sumsq_q;
		end else begin
			case (ctl_s1.dst)
				2'd0:    base = ACC_W'(cross_q[0]);
				2'd1:    base = ACC_W'(cross_q[1]);
				2'd2:    base = ACC_W'(cross_q[2]);
				default: base = '0;
			endcase
		end
		acc_res = ctl_s1.neg ? base - addend : base + addend;
	end

	// the sum of squares is never negative once all terms are in
	assign radicand = pfa_pkg::RAD_W'(unsigned'(sumsq_q));
	assign sq_start = (state_q == ST_ROOT);
	assign sum_ext  = {1'b0, sum_q} + (pfa_pkg::SUM_W + 1)'(sq_root);

	pfa_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.stat     (sq_stat),
		.root     (sq_root)
	);

	// sequencer, vertex count, accumulator and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			mul_vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			mul_vld_s1 <= (state_q == ST_MUL);
			// load a finished polygon, else drop the transaction once taken
			if (finish && last_q) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= (count_q >= CNT_W'(2)) ? ST_DIFF : ST_DONE;
					end
				end
				ST_DIFF: begin
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_ROOT;
				ST_ROOT:  state_q <= ST_WAIT;
				ST_WAIT: begin
					if (sq_stat.done) begin
						// saturate the running sum
						sum_q   <= sum_ext[pfa_pkg::SUM_W] ? '1 : sum_ext[pfa_pkg::SUM_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							count_q    <= '0;
							sum_q      <= '0;
						end else begin
							count_q <= count_inc;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cur_q[0] <= s_tdata[19:0];
			cur_q[1] <= s_tdata[39:20];
			cur_q[2] <= s_tdata[59:40];
			last_q   <= s_tlast;
		end
		if (state_q == ST_DIFF) begin
			for (int i = 0; i < 3; i++) begin
				a_q[i] <= DIFF_W'(prev_q[i]) - DIFF_W'(first_q[i]);
				b_q[i] <= DIFF_W'(cur_q[i]) - DIFF_W'(first_q[i]);
			end
		end
		prod_s1 <= mul_a * mul_b;
		ctl_s1  <= ctl_c;
		if (mul_vld_s1) begin
			if (ctl_s1.to_sum) begin
				sumsq_q <= acc_res;
			end else begin
				for (int i = 0; i < 3; i++) begin
					if (ctl_s1.dst == 2'(i)) begin
						cross_q[i] <= acc_res[CROSS_W-1:0];
					end
				end
			end
		end
		if (finish) begin
			// keep the first vertex of the polygon and the latest one
			for (int i = 0; i < 3; i++) begin
				if (count_q == '0) begin
					first_q[i] <= cur_q[i];
				end
				prev_q[i] <= cur_q[i];
			end
			if (last_q) begin
				m_tdata_q <= too_few ? '0 : sum_q[pfa_pkg::SUM_W-1:1];
				m_tuser_q <= too_few;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ src/pfa_checker.sv @@
// Port-level checker for polygon_fan_area, attached by the bind at the end of this file.
// Depends on pfa_pkg for the area width.

module pfa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [pfa_pkg::AREA_W-1:0]  m_tdata,
	input logic                        m_tuser
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled area transaction changed");

	// a short polygon reports zero area
	a_too_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("too_few set with nonzero area");

	// the sequencer leaves idle on every accepted vertex, so s_tready falls behind it
	a_busy_after_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("vertex accepted on consecutive cycles");

	// a new result appears only as the sequencer returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result raised while a vertex is in work");

endmodule

bind polygon_fan_area pfa_checker u_pfa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
